>>> src/nlp_pkg.sv
// Shared types and constants for the NAL length-prefix to start-code converter.
// No dependencies; every module of the block imports this package.
package nlp_pkg;

	// Configuration register indexes.
	localparam logic REG_LENGTH_SIZE  = 1'b0;
	localparam logic REG_OUTPUT_LIMIT = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [23:0] sample_bytes;
		logic        end_of_sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       failed;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  length_size;
		logic [23:0] output_limit;
	} cfg_t;

	// One classified input byte: up to four bytes to emit, first in bytes[0].
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic            last;
		logic            failed;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_PASS    = 4'b0100,
		PH_DROP    = 4'b1000
	} phase_t;

endpackage

>>> src/nlp_front.sv
// Front end: tracks prefix/payload state per sample byte and turns each
// accepted byte into at most one queue command. Depends on nlp_pkg.
module nlp_front #(
	parameter int COUNT_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  nlp_pkg::cfg_t     cfg,
	input  logic            item_valid,
	output logic            item_ready,
	input  nlp_pkg::in_item_t item,
	output logic            push,
	input  logic            push_ready,
	output nlp_pkg::cmd_t     cmd
);
	import nlp_pkg::*;

	localparam int SW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 2;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	phase_t                phase_q, ph, ph_d;
	logic [1:0]            pidx_q, pidx_d;
	logic [31:0]           acc_q, acc_d, acc_n, held;
	logic [COUNT_BITS-1:0] pos_q, pos_d, pl_q, pl_d, pl_dec, oc_q, oc_d, nal_cap;
	logic [COUNT_BITS:0]   pos_inc, oc_inc1, oc_inc4;
	logic                  rej_q, rej, first, active, done, bad, over, accept;
	logic [2:0]            lsz_q, lsz, lsz_cfg, pidx_inc, n;
	logic [23:0]           limit_q, lim;
	logic [SW-1:0]         size_x, pos_x, nal_x;

	assign item_ready = push_ready;
	assign accept     = item_valid && push_ready;

	always_comb begin
		if (cfg.length_size == 3'd0)
			lsz_cfg = 3'd1;
		else if (cfg.length_size > 3'd4)
			lsz_cfg = 3'd4;
		else
			lsz_cfg = cfg.length_size;
	end

	always_comb begin
		first   = (pos_q == '0);
		lsz     = first ? lsz_cfg : lsz_q;
		lim     = first ? cfg.output_limit : limit_q;
		rej     = first ? (item.sample_bytes > cfg.output_limit) : rej_q;
		size_x  = SW'(item.sample_bytes);
		pos_x   = SW'(pos_q);
		active  = !rej && (pos_x < size_x);
		acc_n   = {acc_q[23:0], item.data_byte};
		nal_x   = SW'(acc_n);
		pidx_inc = {1'b0, pidx_q} + 3'd1;
		done    = (pidx_inc >= lsz);
		bad     = (acc_n == 32'd0) || (pos_x + SW'(1) + nal_x > size_x);
		over    = (SW'(oc_q) + SW'(4) + nal_x > SW'(lim));
		nal_cap = (nal_x > SW'(CNT_MAX)) ? CNT_MAX : acc_n[COUNT_BITS-1:0];
		// held prefix bytes moved to the top so the oldest lands in bytes[0]
		held    = acc_n << {3'd4 - pidx_inc, 3'b000};
		pos_inc = {1'b0, pos_q} + (COUNT_BITS+1)'(1);
		oc_inc1 = {1'b0, oc_q} + (COUNT_BITS+1)'(1);
		oc_inc4 = {1'b0, oc_q} + (COUNT_BITS+1)'(4);
		pl_dec  = (pl_q != '0) ? pl_q - COUNT_BITS'(1) : pl_q;

		ph = phase_q;
		// prefix that cannot fit in the rest of the sample
		if (active && phase_q == PH_PREFIX && pidx_q == 2'd0 && pos_x + SW'(lsz) > size_x)
			ph = (lsz == 3'd4) ? PH_PASS : PH_DROP;

		ph_d   = ph;
		pidx_d = pidx_q;
		acc_d  = acc_q;
		pl_d   = pl_q;
		oc_d   = oc_q;
		n      = 3'd0;
		cmd    = '0;
		cmd.byte_valid = 1'b1;

		if (active) begin
			unique case (ph)
				PH_PREFIX: begin
					acc_d  = acc_n;
					pidx_d = pidx_inc[1:0];
					if (done) begin
						pidx_d = 2'd0;
						acc_d  = '0;
						if (lsz == 3'd4) begin
							n = 3'd4;
							if (bad) begin
								cmd.bytes[0] = acc_n[31:24];
								cmd.bytes[1] = acc_n[23:16];
								cmd.bytes[2] = acc_n[15:8];
								cmd.bytes[3] = acc_n[7:0];
								ph_d = PH_PASS;
							end else begin
								cmd.bytes[3] = 8'd1;
								pl_d = nal_cap;
								ph_d = PH_PAYLOAD;
							end
						end else if (bad || over) begin
							ph_d = PH_DROP;
						end else begin
							n = 3'd4;
							cmd.bytes[3] = 8'd1;
							oc_d = oc_inc4[COUNT_BITS] ? CNT_MAX : oc_inc4[COUNT_BITS-1:0];
							pl_d = nal_cap;
							ph_d = PH_PAYLOAD;
						end
					end else if (item.end_of_sample && lsz == 3'd4) begin
						n = pidx_inc;
						cmd.bytes[0] = held[31:24];
						cmd.bytes[1] = held[23:16];
						cmd.bytes[2] = held[15:8];
					end
				end
				PH_PAYLOAD: begin
					n = 3'd1;
					cmd.bytes[0] = item.data_byte;
					oc_d = oc_inc1[COUNT_BITS] ? CNT_MAX : oc_inc1[COUNT_BITS-1:0];
					pl_d = pl_dec;
					if (pl_dec == '0)
						ph_d = PH_PREFIX;
				end
				PH_PASS: begin
					n = 3'd1;
					cmd.bytes[0] = item.data_byte;
				end
				PH_DROP: begin
				end
				default: begin
				end
			endcase
		end

		pos_d = pos_inc[COUNT_BITS] ? CNT_MAX : pos_inc[COUNT_BITS-1:0];

		if (item.end_of_sample) begin
			if (n == 3'd0) begin
				// bare end marker
				n = 3'd1;
				cmd.bytes      = '0;
				cmd.byte_valid = 1'b0;
				cmd.failed     = rej;
			end
			cmd.last = 1'b1;
			ph_d   = PH_PREFIX;
			pidx_d = 2'd0;
			acc_d  = '0;
			pos_d  = '0;
			pl_d   = '0;
			oc_d   = '0;
		end
		cmd.last_idx = 2'(n - 3'd1);
	end

	assign push = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pidx_q  <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
			pl_q    <= '0;
			oc_q    <= '0;
			rej_q   <= 1'b0;
			lsz_q   <= 3'd4;
			limit_q <= '1;
		end else if (accept) begin
			phase_q <= ph_d;
			pidx_q  <= pidx_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			pl_q    <= pl_d;
			oc_q    <= oc_d;
			rej_q   <= item.end_of_sample ? 1'b0 : rej;
			lsz_q   <= lsz;
			limit_q <= lim;
		end
	end

	a_fail_is_marker: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.failed |-> cmd.last && !cmd.byte_valid)
		else $error("failed flag on a non-marker command");

endmodule

>>> src/nlp_fifo.sv
// Short command queue between the front end and the output sequencer.
// Depends on nlp_pkg for the command type.
module nlp_fifo #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        push_ready,
	input  nlp_pkg::cmd_t wr_data,
	output logic        pop_valid,
	input  logic        pop,
	output nlp_pkg::cmd_t rd_data
);
	import nlp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign rd_data    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CW'(DEPTH))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from an empty queue");

endmodule

>>> src/nlp_back.sv
// Output sequencer: unrolls each queued command into one byte per cycle
// while the output is ready and holds it there. Depends on nlp_pkg.
module nlp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  nlp_pkg::cmd_t    cmd,
	output logic           stream_valid,
	input  logic           stream_ready,
	output nlp_pkg::out_item_t stream
);
	import nlp_pkg::*;

	cmd_t       cmd_q;
	logic       busy_q, at_end, fire;
	logic [1:0] idx_q;

	assign at_end       = (idx_q == cmd_q.last_idx);
	assign fire         = busy_q && stream_ready;
	assign cmd_pop      = cmd_valid && (!busy_q || (fire && at_end));
	assign stream_valid = busy_q;

	always_comb begin
		stream.out_byte   = cmd_q.bytes[idx_q];
		stream.byte_valid = cmd_q.byte_valid;
		stream.last       = cmd_q.last && at_end;
		stream.failed     = cmd_q.failed;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (at_end)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !cmd_q.byte_valid |-> cmd_q.last_idx == 2'd0 && cmd_q.last)
		else $error("end marker not a lone final item");

endmodule

>>> src/nal_length_prefix_to_start_code_core.sv
// Converts length-prefixed NAL units of one video sample into a start-code
// stream. Each sample byte is taken whenever the 4-entry command queue
// has room, and one output item leaves per cycle while stream_ready is
// high, so the block sustains one byte per cycle; each prefix that is not
// dropped becomes four output items, so with 1- to 3-byte prefixes the
// output port sets the pace and input stalls while the queue is full. An
// item passes through the command queue and the sequencer's command
// register before it is offered on the output. Write configuration only
// while the block is idle; it is latched on each sample's first byte.
// Depends on nlp_pkg, nlp_front, nlp_fifo and nlp_back.
module nal_length_prefix_to_start_code_core #(
	parameter int COUNT_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [23:0]        cfg_wdata,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  nlp_pkg::in_item_t  sample,
	output logic               stream_valid,
	input  logic               stream_ready,
	output nlp_pkg::out_item_t stream
);
	import nlp_pkg::*;

	cfg_t cfg_q;
	cmd_t push_cmd, pop_cmd;
	logic push, push_ready, pop_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_size  <= 3'd4;
			cfg_q.output_limit <= '1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LENGTH_SIZE:  cfg_q.length_size  <= cfg_wdata[2:0];
				REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	nlp_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (sample_valid),
		.item_ready (sample_ready),
		.item       (sample),
		.push       (push),
		.push_ready (push_ready),
		.cmd        (push_cmd)
	);

	nlp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.wr_data    (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.rd_data    (pop_cmd)
	);

	nlp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (pop_valid),
		.cmd_pop      (pop),
		.cmd          (pop_cmd),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream       (stream)
	);

endmodule
